// File: hdl/y4mp_pkg.sv
// Shared types, codes and constant tables for the y4m stream header parser.
`default_nettype none

package y4mp_pkg;

	typedef enum logic [1:0] {
		PH_MAGIC  = 2'd0,
		PH_HEADER = 2'd1,
		PH_MARKER = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		TK_NONE = 3'd0,
		TK_W    = 3'd1,
		TK_H    = 3'd2,
		TK_F    = 3'd3,
		TK_C    = 3'd4,
		TK_I    = 3'd5
	} token_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_MAGIC = 3'd1,
		ST_TOO_LONG  = 3'd2,
		ST_NO_MARKER = 3'd3,
		ST_BAD_DIGIT = 3'd4
	} status_t;

	localparam logic [1:0] CHROMA_420 = 2'd0;
	localparam logic [1:0] CHROMA_422 = 2'd1;
	localparam logic [1:0] CHROMA_444 = 2'd2;

	localparam logic [1:0] ORDER_PROG   = 2'd0;
	localparam logic [1:0] ORDER_TOP    = 2'd1;
	localparam logic [1:0] ORDER_BOTTOM = 2'd2;

	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_COLON = 8'h3A;

	localparam logic [7:0]  MAGIC_LEN   = 8'd10;
	localparam logic [2:0]  MARKER_LEN  = 3'd6;
	localparam logic [31:0] RATE_NUM_RESET = 32'd25;
	localparam logic [31:0] RATE_DEN_RESET = 32'd1;

	typedef struct packed {
		logic [7:0] stream_byte;
		logic       stream_start;
	} byte_item_t;

	typedef struct packed {
		logic [2:0]  parse_status;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [31:0] rate_numerator;
		logic [31:0] rate_denominator;
		logic [1:0]  chroma_format;
		logic [1:0]  field_order;
		logic [33:0] frame_bytes;
		logic [7:0]  header_length;
	} result_item_t;

	// Expected bytes of the "YUV4MPEG2 " stream signature.
	function automatic logic [7:0] magic_byte(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = "Y";
			4'd1: c = "U";
			4'd2: c = "V";
			4'd3: c = "4";
			4'd4: c = "M";
			4'd5: c = "P";
			4'd6: c = "E";
			4'd7: c = "G";
			4'd8: c = "2";
			4'd9: c = CHAR_SPACE;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Expected bytes of the "FRAME" marker and its newline.
	function automatic logic [7:0] marker_byte(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = "F";
			3'd1: c = "R";
			3'd2: c = "A";
			3'd3: c = "M";
			3'd4: c = "E";
			3'd5: c = CHAR_LF;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// File: hdl/y4mp_dec_acc.sv
// Saturating decimal accumulator step: acc * 10 + digit, clamped to all ones.
`default_nettype none

module y4mp_dec_acc #(
	parameter int WIDTH = 16
) (
	input  wire logic [WIDTH-1:0] acc,
	input  wire logic [3:0]       digit,
	output logic      [WIDTH-1:0] sum
);

	logic [WIDTH+3:0] wide;

	// Times ten as two shifted copies, so no multiplier is needed.
	assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{WIDTH{1'b0}}, digit};
	assign sum  = (wide[WIDTH+3:WIDTH] != 4'd0) ? {WIDTH{1'b1}} : wide[WIDTH-1:0];

endmodule

`default_nettype wire

// File: hdl/y4m_stream_header_parser_unit.sv
// Top level of the y4m stream header parser: byte-wide parse state and result register.
// Registered result: result_valid rises in the cycle after the parse-ending byte.
// Throughput: one stream byte per cycle; a byte is refused only while a result is held.
// The frame byte count uses area_q, the registered product of width_q and height_q,
// which settles well before the six marker bytes have passed.
// Reset: arst_n clears the parse state to the magic check and empties the result register.
`default_nettype none

module y4m_stream_header_parser_unit
	import y4mp_pkg::*;
#(
	parameter int HEADER_LIMIT = 240
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         byte_valid,
	output logic              byte_ready,
	input  wire byte_item_t   byte_item,
	output logic              result_valid,
	input  wire logic         result_ready,
	output result_item_t      result_item
);

	// Parse state registers.
	phase_t      phase_q;
	logic [7:0]  pos_q;
	logic [7:0]  tok_off_q;
	token_t      tok_kind_q;
	logic        after_colon_q;
	logic [1:0]  chroma_match_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] num_q;
	logic [31:0] den_q;
	logic [1:0]  chroma_q;
	logic [1:0]  order_q;
	logic [2:0]  marker_idx_q;

	// Luma area, recomputed every cycle from the dimension accumulators.
	logic [31:0] area_q;

	// Result register.
	logic         result_valid_q;
	result_item_t result_q;

	// Current state, with a stream start folded in as an immediate restart.
	phase_t      cur_phase;
	logic [7:0]  cur_pos;
	logic [7:0]  cur_off;
	token_t      cur_kind;
	logic        cur_colon;
	logic [1:0]  cur_match;
	logic [15:0] cur_width;
	logic [15:0] cur_height;
	logic [31:0] cur_num;
	logic [31:0] cur_den;
	logic [1:0]  cur_chroma;
	logic [1:0]  cur_order;
	logic [2:0]  cur_midx;

	// Next state.
	phase_t      nxt_phase;
	logic [7:0]  nxt_pos;
	logic [7:0]  nxt_off;
	token_t      nxt_kind;
	logic        nxt_colon;
	logic [1:0]  nxt_match;
	logic [15:0] nxt_width;
	logic [15:0] nxt_height;
	logic [31:0] nxt_num;
	logic [31:0] nxt_den;
	logic [1:0]  nxt_chroma;
	logic [1:0]  nxt_order;
	logic [2:0]  nxt_midx;

	logic        fire;
	logic [7:0]  b;
	logic        is_digit;
	logic [3:0]  digit;
	logic        is_sep;
	logic        too_long;
	logic        finish;
	status_t     fin_status;
	logic [15:0] width_step;
	logic [15:0] height_step;
	logic [31:0] num_step;
	logic [31:0] den_step;
	logic [33:0] area_x3;
	logic [33:0] frame_bytes;
	result_item_t result_d;

	assign fire       = byte_valid && byte_ready;
	assign byte_ready = !result_valid_q || result_ready;

	assign b        = byte_item.stream_byte;
	assign is_digit = (b >= "0") && (b <= "9");
	assign digit    = is_digit ? 4'(b - 8'h30) : 4'd0;
	assign is_sep   = (b == CHAR_SPACE) || (b == CHAR_LF);

	always_comb begin
		if (byte_item.stream_start) begin
			cur_phase  = PH_MAGIC;
			cur_pos    = 8'd0;
			cur_off    = 8'd0;
			cur_kind   = TK_NONE;
			cur_colon  = 1'b0;
			cur_match  = 2'd0;
			cur_width  = 16'd0;
			cur_height = 16'd0;
			cur_num    = RATE_NUM_RESET;
			cur_den    = RATE_DEN_RESET;
			cur_chroma = CHROMA_420;
			cur_order  = ORDER_PROG;
			cur_midx   = 3'd0;
		end else begin
			cur_phase  = phase_q;
			cur_pos    = pos_q;
			cur_off    = tok_off_q;
			cur_kind   = tok_kind_q;
			cur_colon  = after_colon_q;
			cur_match  = chroma_match_q;
			cur_width  = width_q;
			cur_height = height_q;
			cur_num    = num_q;
			cur_den    = den_q;
			cur_chroma = chroma_q;
			cur_order  = order_q;
			cur_midx   = marker_idx_q;
		end
	end

	// One decimal step for each numeric field; only the one that the token selects is kept.
	y4mp_dec_acc #(.WIDTH(16)) u_width_acc (
		.acc(cur_width), .digit(digit), .sum(width_step)
	);
	y4mp_dec_acc #(.WIDTH(16)) u_height_acc (
		.acc(cur_height), .digit(digit), .sum(height_step)
	);
	y4mp_dec_acc #(.WIDTH(32)) u_num_acc (
		.acc(cur_num), .digit(digit), .sum(num_step)
	);
	y4mp_dec_acc #(.WIDTH(32)) u_den_acc (
		.acc(cur_den), .digit(digit), .sum(den_step)
	);

	// Header bytes must sit below limit minus one, so a byte at limit minus one fails.
	assign too_long = ({1'b0, cur_pos} + 9'd1) >= 9'(HEADER_LIMIT);

	// Decides whether this byte ends the parse, and with which status.
	always_comb begin
		finish     = 1'b0;
		fin_status = ST_OK;
		case (cur_phase)
			PH_MAGIC: begin
				if ((cur_pos >= MAGIC_LEN) || (b != magic_byte(cur_pos[3:0]))) begin
					finish     = 1'b1;
					fin_status = ST_BAD_MAGIC;
				end
			end
			PH_HEADER: begin
				if (too_long) begin
					finish     = 1'b1;
					fin_status = ST_TOO_LONG;
				end else if (!is_sep && (cur_off != 8'd0)) begin
					if (((cur_kind == TK_W) || (cur_kind == TK_H)) && !is_digit) begin
						finish     = 1'b1;
						fin_status = ST_BAD_DIGIT;
					end else if ((cur_kind == TK_F) && !is_digit &&
					             !((b == CHAR_COLON) && !cur_colon)) begin
						finish     = 1'b1;
						fin_status = ST_BAD_DIGIT;
					end
				end
			end
			PH_MARKER: begin
				if ((cur_midx >= MARKER_LEN) || (b != marker_byte(cur_midx))) begin
					finish     = 1'b1;
					fin_status = ST_NO_MARKER;
				end else if (cur_midx == MARKER_LEN - 3'd1) begin
					finish     = 1'b1;
					fin_status = ST_OK;
				end
			end
			default: begin
				finish = 1'b0;
			end
		endcase
	end

	// Next parse state for the accepted byte.
	always_comb begin
		nxt_phase  = cur_phase;
		nxt_pos    = cur_pos;
		nxt_off    = cur_off;
		nxt_kind   = cur_kind;
		nxt_colon  = cur_colon;
		nxt_match  = cur_match;
		nxt_width  = cur_width;
		nxt_height = cur_height;
		nxt_num    = cur_num;
		nxt_den    = cur_den;
		nxt_chroma = cur_chroma;
		nxt_order  = cur_order;
		nxt_midx   = cur_midx;
		if (finish) begin
			nxt_phase = PH_DONE;
		end else begin
			case (cur_phase)
				PH_MAGIC: begin
					nxt_pos = cur_pos + 8'd1;
					if (cur_pos == MAGIC_LEN - 8'd1) begin
						nxt_phase = PH_HEADER;
						nxt_off   = 8'd0;
						nxt_kind  = TK_NONE;
					end
				end
				PH_HEADER: begin
					nxt_pos = cur_pos + 8'd1;
					if (is_sep) begin
						nxt_off  = 8'd0;
						nxt_kind = TK_NONE;
						if (b == CHAR_LF) begin
							nxt_phase = PH_MARKER;
							nxt_midx  = 3'd0;
						end
					end else begin
						nxt_off = (cur_off != 8'hFF) ? cur_off + 8'd1 : cur_off;
						if (cur_off == 8'd0) begin
							// The token letter selects the field and clears its value.
							case (b)
								"W": begin
									nxt_kind  = TK_W;
									nxt_width = 16'd0;
								end
								"H": begin
									nxt_kind   = TK_H;
									nxt_height = 16'd0;
								end
								"F": begin
									nxt_kind  = TK_F;
									nxt_num   = 32'd0;
									nxt_den   = 32'd0;
									nxt_colon = 1'b0;
								end
								"C": begin
									nxt_kind   = TK_C;
									nxt_chroma = CHROMA_420;
									nxt_match  = 2'd0;
								end
								"I": begin
									nxt_kind  = TK_I;
									nxt_order = ORDER_PROG;
								end
								default: begin
									nxt_kind = TK_NONE;
								end
							endcase
						end else begin
							case (cur_kind)
								TK_W: nxt_width  = width_step;
								TK_H: nxt_height = height_step;
								TK_F: begin
									if ((b == CHAR_COLON) && !cur_colon) begin
										nxt_colon = 1'b1;
									end else if (cur_colon) begin
										nxt_den = den_step;
									end else begin
										nxt_num = num_step;
									end
								end
								TK_C: begin
									if (cur_off == 8'd2) begin
										nxt_match = (b == "2") ? 2'd1 :
										            (b == "4") ? 2'd2 : 2'd0;
									end else if (cur_off == 8'd3) begin
										nxt_chroma = ((cur_match == 2'd1) && (b == "2")) ?
										             CHROMA_422 :
										             ((cur_match == 2'd2) && (b == "4")) ?
										             CHROMA_444 : CHROMA_420;
									end
								end
								TK_I: begin
									if (cur_off == 8'd1) begin
										nxt_order = (b == "t") ? ORDER_TOP :
										            (b == "b") ? ORDER_BOTTOM : ORDER_PROG;
									end
								end
								default: begin
									nxt_kind = cur_kind;
								end
							endcase
						end
					end
				end
				PH_MARKER: begin
					nxt_midx = cur_midx + 3'd1;
				end
				default: begin
					nxt_phase = cur_phase;
				end
			endcase
		end
	end

	// Frame size: the 4:2:0 case is three halves of the area, rounded down.
	assign area_x3 = {2'b00, area_q} + {1'b0, area_q, 1'b0};
	always_comb begin
		case (cur_chroma)
			CHROMA_422: frame_bytes = {1'b0, area_q, 1'b0};
			CHROMA_444: frame_bytes = area_x3;
			default:    frame_bytes = {1'b0, area_x3[33:1]};
		endcase
	end

	// Every field other than the status reads zero on an error.
	always_comb begin
		result_d              = '0;
		result_d.parse_status = fin_status;
		if (fin_status == ST_OK) begin
			result_d.frame_width      = cur_width;
			result_d.frame_height     = cur_height;
			result_d.rate_numerator   = cur_num;
			result_d.rate_denominator = cur_den;
			result_d.chroma_format    = cur_chroma;
			result_d.field_order      = cur_order;
			result_d.frame_bytes      = frame_bytes;
			result_d.header_length    = cur_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_MAGIC;
			pos_q          <= 8'd0;
			tok_off_q      <= 8'd0;
			tok_kind_q     <= TK_NONE;
			after_colon_q  <= 1'b0;
			chroma_match_q <= 2'd0;
			width_q        <= 16'd0;
			height_q       <= 16'd0;
			num_q          <= RATE_NUM_RESET;
			den_q          <= RATE_DEN_RESET;
			chroma_q       <= CHROMA_420;
			order_q        <= ORDER_PROG;
			marker_idx_q   <= 3'd0;
		end else if (fire) begin
			phase_q        <= nxt_phase;
			pos_q          <= nxt_pos;
			tok_off_q      <= nxt_off;
			tok_kind_q     <= nxt_kind;
			after_colon_q  <= nxt_colon;
			chroma_match_q <= nxt_match;
			width_q        <= nxt_width;
			height_q       <= nxt_height;
			num_q          <= nxt_num;
			den_q          <= nxt_den;
			chroma_q       <= nxt_chroma;
			order_q        <= nxt_order;
			marker_idx_q   <= nxt_midx;
		end
	end

	always_ff @(posedge clk) begin
		area_q <= 32'(width_q) * 32'(height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire && finish) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && finish) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result_item  = result_q;

	// A byte that ends the parse leaves the parser parked until the next stream start.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && finish |=> phase_q == PH_DONE)
		else $error("parser did not park after a result");

	// An error result carries nothing but its status.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_item.parse_status != ST_OK) |->
		(result_item.frame_width == 16'd0) && (result_item.frame_bytes == 34'd0) &&
		(result_item.header_length == 8'd0))
		else $error("error result carries nonzero fields");

	// A good header holds at least the signature and its closing newline.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_item.parse_status == ST_OK) |->
		result_item.header_length > MAGIC_LEN)
		else $error("header length shorter than the signature");

	// Input is refused only while a finished result waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> result_valid)
		else $error("input stalled with an empty result register");

	// The marker is only checked after a header newline has been seen.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_MARKER |-> pos_q > MAGIC_LEN)
		else $error("marker phase entered without a header");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the y4m stream header parser: byte driver, result monitor, predictor.

module tb_top;
	import y4mp_pkg::*;

	// Same header limit as the default of the block, so the predictor agrees with the RTL.
	localparam int HEADER_LIMIT = 240;

	// Run shape. Bursts of idling stop once the backlog drops below the quiet tail.
	localparam int RANDOM_BYTES = 880;
	localparam int QUIET_TAIL   = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 300000;

	// The stream signature and the frame marker with its newline, first byte in the top bits.
	localparam logic [79:0] SIGNATURE = "YUV4MPEG2 ";
	localparam logic [47:0] FRAME_TAG = {"FRAME", 8'h0A};

	// One byte waiting to be sent. A hold byte is not offered until every parse result
	// already predicted has been taken from the block.
	typedef struct packed {
		logic       hold;
		byte_item_t item;
	} stim_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         byte_valid = 1'b0;
	logic         byte_ready;
	byte_item_t   byte_item = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_item_t result_item;

	stim_t        stream_backlog[$];
	logic [7:0]   stream_bytes[$];
	result_item_t expected_parses[$];

	int send_gap = 0;
	int take_stall = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int bytes_taken = 0;
	int streams_queued = 0;
	int results_checked = 0;
	int status_tally[0:7];

	// Parse state of the predictor.
	phase_t      ps_phase;
	logic [7:0]  ps_offset;
	logic [7:0]  ps_tok_pos;
	token_t      ps_tok_kind;
	logic        ps_past_colon;
	logic [1:0]  ps_chroma_hint;
	logic [15:0] ps_width;
	logic [15:0] ps_height;
	logic [31:0] ps_rate_num;
	logic [31:0] ps_rate_den;
	logic [1:0]  ps_chroma;
	logic [1:0]  ps_order;
	logic [2:0]  ps_marker_pos;

	y4m_stream_header_parser_unit #(
		.HEADER_LIMIT(HEADER_LIMIT)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_item   (byte_item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_item (result_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic chance(input int n);
		return $urandom_range(0, n - 1) == 0;
	endfunction

	function automatic logic [7:0] sig_char(input int idx);
		return SIGNATURE[79 - 8 * idx -: 8];
	endfunction

	function automatic logic [7:0] tag_char(input int idx);
		return FRAME_TAG[47 - 8 * idx -: 8];
	endfunction

	// Decimal accumulation with saturation. Digits are 0x30..0x39, so the low nibble
	// is the digit value.
	function automatic logic [31:0] append_digit(input logic [31:0] acc, input logic [7:0] ch,
			input logic [31:0] cap);
		logic [63:0] v;
		v = 64'(acc) * 64'd10 + 64'(ch[3:0]);
		return (v > 64'(cap)) ? cap : v[31:0];
	endfunction

	//------------------------------------------------------------------------------------
	// Predictor
	//------------------------------------------------------------------------------------

	task automatic reset_parse();
		ps_phase       = PH_MAGIC;
		ps_offset      = '0;
		ps_tok_pos     = '0;
		ps_tok_kind    = TK_NONE;
		ps_past_colon  = 1'b0;
		ps_chroma_hint = CHROMA_420;
		ps_width       = '0;
		ps_height      = '0;
		ps_rate_num    = RATE_NUM_RESET;
		ps_rate_den    = RATE_DEN_RESET;
		ps_chroma      = CHROMA_420;
		ps_order       = ORDER_PROG;
		ps_marker_pos  = '0;
	endtask

	// Ends the parse. An error result carries only its status; a good one carries the
	// collected parameters and the size of one frame.
	task automatic conclude(input status_t st);
		result_item_t r;
		logic [63:0]  area;
		logic [63:0]  fb;
		r = '0;
		r.parse_status = st;
		if (st == ST_OK) begin
			area = 64'(ps_width) * 64'(ps_height);
			case (ps_chroma)
				CHROMA_422: fb = area * 64'd2;
				CHROMA_444: fb = area * 64'd3;
				default:    fb = (area * 64'd3) >> 1;
			endcase
			r.frame_width      = ps_width;
			r.frame_height     = ps_height;
			r.rate_numerator   = ps_rate_num;
			r.rate_denominator = ps_rate_den;
			r.chroma_format    = ps_chroma;
			r.field_order      = ps_order;
			r.frame_bytes      = fb[33:0];
			r.header_length    = ps_offset;
		end
		expected_parses.push_back(r);
		ps_phase = PH_DONE;
	endtask

	task automatic parse_byte(input byte_item_t it);
		logic [7:0] b;
		logic       is_digit;
		logic       bad;
		b = it.stream_byte;
		is_digit = (b >= "0") && (b <= "9");
		bad = 1'b0;
		if (it.stream_start)
			reset_parse();
		case (ps_phase)
			PH_MAGIC: begin
				if (ps_offset >= MAGIC_LEN || b != sig_char(int'(ps_offset))) begin
					conclude(ST_BAD_MAGIC);
				end else begin
					ps_offset++;
					if (ps_offset == MAGIC_LEN) begin
						ps_phase    = PH_HEADER;
						ps_tok_pos  = '0;
						ps_tok_kind = TK_NONE;
					end
				end
			end
			PH_HEADER: begin
				if (int'(ps_offset) + 1 >= HEADER_LIMIT) begin
					conclude(ST_TOO_LONG);
				end else if (b == CHAR_SPACE || b == CHAR_LF) begin
					ps_tok_pos  = '0;
					ps_tok_kind = TK_NONE;
					ps_offset++;
					if (b == CHAR_LF) begin
						ps_phase      = PH_MARKER;
						ps_marker_pos = '0;
					end
				end else begin
					if (ps_tok_pos == 8'd0) begin
						// The first byte names the token and clears what that token sets.
						ps_tok_kind = TK_NONE;
						case (b)
							"W": begin
								ps_tok_kind = TK_W;
								ps_width    = '0;
							end
							"H": begin
								ps_tok_kind = TK_H;
								ps_height   = '0;
							end
							"F": begin
								ps_tok_kind   = TK_F;
								ps_rate_num   = '0;
								ps_rate_den   = '0;
								ps_past_colon = 1'b0;
							end
							"C": begin
								ps_tok_kind    = TK_C;
								ps_chroma      = CHROMA_420;
								ps_chroma_hint = CHROMA_420;
							end
							"I": begin
								ps_tok_kind = TK_I;
								ps_order    = ORDER_PROG;
							end
							default: ;
						endcase
					end else begin
						case (ps_tok_kind)
							TK_W, TK_H: begin
								if (!is_digit)
									bad = 1'b1;
								else if (ps_tok_kind == TK_W)
									ps_width = 16'(append_digit(32'(ps_width), b, 32'h0000_FFFF));
								else
									ps_height = 16'(append_digit(32'(ps_height), b, 32'h0000_FFFF));
							end
							TK_F: begin
								if (b == CHAR_COLON && !ps_past_colon)
									ps_past_colon = 1'b1;
								else if (!is_digit)
									bad = 1'b1;
								else if (ps_past_colon)
									ps_rate_den = append_digit(ps_rate_den, b, 32'hFFFF_FFFF);
								else
									ps_rate_num = append_digit(ps_rate_num, b, 32'hFFFF_FFFF);
							end
							TK_C: begin
								// Only the third and fourth bytes of the token matter.
								if (ps_tok_pos == 8'd2)
									ps_chroma_hint = (b == "2") ? CHROMA_422 :
										(b == "4") ? CHROMA_444 : CHROMA_420;
								else if (ps_tok_pos == 8'd3)
									ps_chroma = (ps_chroma_hint == CHROMA_422 && b == "2") ? CHROMA_422 :
										(ps_chroma_hint == CHROMA_444 && b == "4") ? CHROMA_444 :
										CHROMA_420;
							end
							TK_I: begin
								if (ps_tok_pos == 8'd1)
									ps_order = (b == "t") ? ORDER_TOP :
										(b == "b") ? ORDER_BOTTOM : ORDER_PROG;
							end
							default: ;
						endcase
					end
					if (bad) begin
						conclude(ST_BAD_DIGIT);
					end else begin
						if (ps_tok_pos != 8'd255)
							ps_tok_pos++;
						ps_offset++;
					end
				end
			end
			PH_MARKER: begin
				if (ps_marker_pos >= MARKER_LEN || b != tag_char(int'(ps_marker_pos))) begin
					conclude(ST_NO_MARKER);
				end else begin
					ps_marker_pos++;
					if (ps_marker_pos == MARKER_LEN)
						conclude(ST_OK);
				end
			end
			default: ;
		endcase
	endtask

	//------------------------------------------------------------------------------------
	// Stream construction
	//------------------------------------------------------------------------------------

	task automatic add_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			stream_bytes.push_back(s[i]);
	endtask

	task automatic add_digits(input int n);
		int i;
		for (i = 0; i < n; i++)
			stream_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
	endtask

	task automatic add_random(input int n);
		int i;
		for (i = 0; i < n; i++)
			stream_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Filler of an ignored token, used to push the header toward its length limit.
	task automatic add_fill(input int n);
		int i;
		for (i = 0; i < n; i++)
			stream_bytes.push_back("x");
	endtask

	// A rare stray byte after a numeric token; usually not a digit, so a bad digit.
	task automatic add_stray_byte();
		if (chance(30))
			add_random(1);
	endtask

	// Mostly short numbers; now and then long enough to saturate.
	function automatic int pick_len();
		return chance(12) ? int'($urandom_range(5, 12)) : int'($urandom_range(1, 4));
	endfunction

	// Moves the assembled bytes to the backlog. The first byte may restart the parser.
	task automatic queue_stream(input logic restart, input logic hold);
		stim_t s;
		int    i;
		for (i = 0; i < stream_bytes.size(); i++) begin
			s.item.stream_byte  = stream_bytes[i];
			s.item.stream_start = restart && (i == 0);
			s.hold              = hold && (i == 0);
			stream_backlog.push_back(s);
		end
		streams_queued++;
	endtask

	task automatic queue_text(input string s, input logic restart, input logic hold);
		stream_bytes.delete();
		add_text(s);
		queue_stream(restart, hold);
	endtask

	task automatic add_token();
		case ($urandom_range(0, 9))
			0, 1: begin
				add_text("W");
				add_digits(pick_len());
				add_stray_byte();
			end
			2, 3: begin
				add_text("H");
				add_digits(pick_len());
				add_stray_byte();
			end
			4: begin
				add_text("F");
				if (!chance(8))
					add_digits(pick_len());
				if (!chance(6)) begin
					add_text(":");
					if (!chance(8))
						add_digits(pick_len());
				end
				add_stray_byte();
			end
			5: begin
				case ($urandom_range(0, 11))
					0:  add_text("C420jpeg");
					1:  add_text("C420paldv");
					2:  add_text("C420mpeg2");
					3:  add_text("C422");
					4:  add_text("C444");
					5:  add_text("C444alpha");
					6:  add_text("Cmono");
					7:  add_text("C4");
					8:  add_text("C44");
					9:  add_text("C424");
					10: add_text("C442");
					default: begin
						add_text("C");
						add_random($urandom_range(0, 4));
					end
				endcase
			end
			6: begin
				case ($urandom_range(0, 6))
					0, 1: add_text("It");
					2, 3: add_text("Ib");
					4:    add_text("Ip");
					5:    add_text("I");
					default: begin
						add_text("I");
						add_random(1);
					end
				endcase
			end
			7: begin
				if (chance(2))
					add_text("A1:1");
				else
					add_text("XYSCSS=420JPEG");
			end
			8: ;  // empty token: two separators in a row
			default: add_random($urandom_range(1, 6));
		endcase
	endtask

	// A well-formed header with random content, with now and then a broken signature,
	// an overlong header, a broken marker or a cut-off stream.
	task automatic compose_header_stream();
		int ntok;
		int k;
		stream_bytes.delete();
		add_text("YUV4MPEG2 ");
		if (chance(12))
			stream_bytes[$urandom_range(0, 9)] = 8'($urandom_range(0, 255));
		ntok = $urandom_range(0, 7);
		for (k = 0; k < ntok; k++) begin
			if (k > 0)
				stream_bytes.push_back(CHAR_SPACE);
			add_token();
		end
		if (chance(20)) begin
			stream_bytes.push_back(CHAR_SPACE);
			add_text("X");
			add_fill($urandom_range(180, 235));
		end
		stream_bytes.push_back(CHAR_LF);
		add_text("FRAME");
		stream_bytes.push_back(CHAR_LF);
		if (chance(12))
			stream_bytes[stream_bytes.size() - 1 - $urandom_range(0, 5)] = 8'($urandom_range(0, 255));
		if (chance(25)) begin
			k = $urandom_range(1, stream_bytes.size() - 1);
			while (stream_bytes.size() > k)
				stream_bytes.delete(stream_bytes.size() - 1);
		end
	endtask

	// Noise: a piece of the signature, then random bytes.
	task automatic compose_noise_stream();
		int k;
		int i;
		stream_bytes.delete();
		k = $urandom_range(0, 10);
		for (i = 0; i < k; i++)
			stream_bytes.push_back(sig_char(i));
		add_random($urandom_range(1, 8));
	endtask

	//------------------------------------------------------------------------------------
	// Driver: offers the backlog one byte at a time, with random idle bursts.
	//------------------------------------------------------------------------------------

	always @(posedge clk) begin : send_bytes
		stim_t nxt;
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else begin
			if (byte_valid && byte_ready) begin
				parse_byte(byte_item);
				bytes_taken++;
			end
			// A new byte may go out only when the channel is empty or its byte was just taken.
			if (!byte_valid || byte_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					byte_valid <= 1'b0;
				end else if (stream_backlog.size() > 0 &&
						!(stream_backlog[0].hold && expected_parses.size() > 0)) begin
					if (stream_backlog.size() > QUIET_TAIL && chance(6)) begin
						send_gap = $urandom_range(1, 13) - 1;
						byte_valid <= 1'b0;
					end else begin
						nxt = stream_backlog.pop_front();
						byte_item  <= nxt.item;
						byte_valid <= 1'b1;
					end
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	//------------------------------------------------------------------------------------
	// Monitor: takes results with random stall bursts and checks them in order.
	//------------------------------------------------------------------------------------

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : take_results
		result_item_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_parses.size() == 0) begin
					$error("result with no parse pending, status %0d", result_item.parse_status);
					mismatches++;
				end else begin
					want = expected_parses.pop_front();
					check_field("parse_status", 64'(want.parse_status), 64'(result_item.parse_status));
					check_field("frame_width", 64'(want.frame_width), 64'(result_item.frame_width));
					check_field("frame_height", 64'(want.frame_height), 64'(result_item.frame_height));
					check_field("rate_numerator", 64'(want.rate_numerator),
						64'(result_item.rate_numerator));
					check_field("rate_denominator", 64'(want.rate_denominator),
						64'(result_item.rate_denominator));
					check_field("chroma_format", 64'(want.chroma_format),
						64'(result_item.chroma_format));
					check_field("field_order", 64'(want.field_order), 64'(result_item.field_order));
					check_field("frame_bytes", 64'(want.frame_bytes), 64'(result_item.frame_bytes));
					check_field("header_length", 64'(want.header_length),
						64'(result_item.header_length));
					status_tally[want.parse_status]++;
					results_checked++;
				end
			end
			if (take_stall > 0) begin
				take_stall--;
				result_ready <= 1'b0;
			end else if (stream_backlog.size() > QUIET_TAIL && chance(5)) begin
				take_stall = $urandom_range(1, 13) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d parses still pending",
				cycle_count, expected_parses.size());
			$display("FAILURE");
			$finish;
		end
	end

	//------------------------------------------------------------------------------------
	// Stimulus, reset and end of run
	//------------------------------------------------------------------------------------

	initial begin
		int target;
		foreach (status_tally[i])
			status_tally[i] = 0;
		reset_parse();

		// Directed streams. The first one comes without a restart flag, straight after reset.
		queue_text("YUV4MPEG2 \nFRAME\n", 1'b0, 1'b0);
		// Largest values everywhere; the sender waits here for the first result.
		queue_text("YUV4MPEG2 W65535 H65535 F4294967295:4294967295 C444 Ib\nFRAME\n",
			1'b1, 1'b1);
		// Saturating width, height and rate, no colon, double space and ignored tokens.
		queue_text("YUV4MPEG2 W99999 H070000 F123456789012 C422 It  A1:1 X\nFRAME\n",
			1'b1, 1'b0);
		// Bare tokens: empty width, short chroma, bare interlace, rate of only a colon.
		queue_text("YUV4MPEG2 W C4 I F:\nFRAME\n", 1'b1, 1'b0);
		queue_text("YUV4MPEG2 C4x4 Ixyz F30\nFRAME\n", 1'b1, 1'b0);
		queue_text("YUV4MPEG2 W3 H1\nFRAME\n", 1'b1, 1'b0);
		queue_text("YUV4MPEG2 W1 H1 C422\nFRAME\n", 1'b1, 1'b0);
		// Broken signature; the rest of the stream is ignored.
		queue_text("YUV5MPEG2 ", 1'b1, 1'b0);
		// Bad digits in a width and in a rate with a second colon.
		queue_text("YUV4MPEG2 W12x\n", 1'b1, 1'b0);
		queue_text("YUV4MPEG2 H7 F1:2:3\n", 1'b1, 1'b0);
		// Frame marker wrong, and a token where the marker should start.
		queue_text("YUV4MPEG2 W8 H8\nFRAMX\n", 1'b1, 1'b0);
		queue_text("YUV4MPEG2 W8\nW", 1'b1, 1'b0);
		// Header ending on the last allowed byte, then one byte too late.
		stream_bytes.delete();
		add_text("YUV4MPEG2 X");
		add_fill(227);
		add_text("\nFRAME\n");
		queue_stream(1'b1, 1'b0);
		stream_bytes.delete();
		add_text("YUV4MPEG2 ");
		add_fill(229);
		add_text("\nFRAME\n");
		queue_stream(1'b1, 1'b0);
		// A restart in the middle of a header, then bytes after a result that are ignored.
		queue_text("YUV4MPEG2 W10 H2", 1'b1, 1'b0);
		queue_text("YUV4MPEG2 W4 H2 C420paldv Ip\nFRAME\n", 1'b1, 1'b0);
		queue_text("FRAME\n", 1'b0, 1'b0);

		// Random part: mostly well-formed headers, some noise and stray bytes.
		target = stream_backlog.size() + RANDOM_BYTES;
		while (stream_backlog.size() < target) begin
			if (chance(7))
				compose_noise_stream();
			else
				compose_header_stream();
			queue_stream(1'b1, chance(10));
			if (chance(8)) begin
				stream_bytes.delete();
				add_random($urandom_range(1, 4));
				queue_stream(1'b0, 1'b0);
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (stream_backlog.size() > 0 || byte_valid || expected_parses.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_parses.size() > 0) begin
			$error("%0d parse results never arrived", expected_parses.size());
			mismatches++;
		end

		$display("Sent %0d bytes in %0d streams and checked %0d parse results, %0d mismatches.",
			bytes_taken, streams_queued, results_checked, mismatches);
		$display("Results: ok %0d, bad magic %0d, too long %0d, no marker %0d, bad digit %0d.",
			status_tally[ST_OK], status_tally[ST_BAD_MAGIC], status_tally[ST_TOO_LONG],
			status_tally[ST_NO_MARKER], status_tally[ST_BAD_DIGIT]);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
